### rtl/gbpc_pkg.sv
// ----------------------------------------------------------------------------
// gbpc_pkg
// Shared types, constants and helpers of the graph search engine.
// ----------------------------------------------------------------------------
package gbpc_pkg;

  localparam int MAX_NODES   = 32;
  localparam int MAX_DEGREE  = 32;
  localparam int MAX_RESULTS = 32;
  localparam int NODE_W      = 5;
  localparam int CNT_W       = 6;
  localparam int LIST_AW     = 10;
  localparam int LIST_DEPTH  = MAX_NODES * MAX_DEGREE;
  localparam int PADDR_W     = 3;

  // register indexes (paddr[2])
  localparam logic REG_USER_COUNT = 1'b0;

  // operation codes
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_PATH    = 3'd2;
  localparam logic [2:0] OP_GROUPS  = 3'd3;
  localparam logic [2:0] OP_SUGGEST = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] group_index;
    logic [NODE_W-1:0] score;
    logic              last;
  } result_t;

  // one result from the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    logic              fin;
    logic [1:0]        status;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] group_index;
    logic [NODE_W-1:0] score;
  } put_t;

  // mutual count saturates at 31
  function automatic logic [NODE_W-1:0] sat_score(input logic [CNT_W-1:0] v);
    sat_score = v[CNT_W-1] ? '1 : v[NODE_W-1:0];
  endfunction

endpackage

### rtl/graph_bfs_path_component_engine_core.sv
// ----------------------------------------------------------------------------
// graph_bfs_path_component_engine_core
// Undirected graph engine: edge add/remove, shortest path, components and
// friend-of-friend suggestions over ordered neighbour lists.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. Results leave one per
// strobe cycle, each held in the result stage until the sequencer gives the
// next one or finishes, and the receiver cannot stall them; the final one
// has last set and is on the ports during the first cycle that busy is low
// again, so a new request may be taken at the edge ending it. The single
// read port of the neighbour-list memory is scanned one entry a cycle. The
// user count is to be written over the APB port only while busy is low; the
// block itself does not enforce it.
module graph_bfs_path_component_engine_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  gbpc_pkg::req_t                req,
  output gbpc_pkg::result_t             result,
  output logic                          result_strobe,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gbpc_pkg::*;

  logic [CNT_W-1:0]   user_active;
  put_t               put;
  logic               ram_we, ram_re;
  logic [LIST_AW-1:0] ram_waddr, ram_raddr;
  logic [NODE_W-1:0]  ram_wdata, ram_rdata;

  // configuration registers
  gbpc_apb u_apb (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .user_active
  );

  // neighbour lists, one row of MAX_DEGREE entries per node
  gbpc_ram #(.WIDTH(NODE_W), .DEPTH(LIST_DEPTH)) u_list (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // sequencer and scan unit
  gbpc_seq u_seq (
    .clk, .rst, .start, .req, .nn(user_active), .busy, .put,
    .ram_we, .ram_waddr, .ram_wdata, .ram_re, .ram_raddr, .ram_rdata
  );

  // result stage
  gbpc_out u_out (
    .clk, .rst, .put, .result, .result_strobe
  );

endmodule

### rtl/gbpc_ram.sv
// ----------------------------------------------------------------------------
// gbpc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/gbpc_apb.sv
// ----------------------------------------------------------------------------
// gbpc_apb
// Configuration register block: user count, clamped to the node limit.
// ----------------------------------------------------------------------------
module gbpc_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [gbpc_pkg::CNT_W-1:0]    user_active
);
  import gbpc_pkg::*;

  logic [CNT_W-1:0] user_count;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_USER_COUNT);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      user_count <= '0;
    end else if (wr_en) begin
      user_count <= pwdata[CNT_W-1:0];
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_USER_COUNT) ? {{(32-CNT_W){1'b0}}, user_count} : '0;

  // nodes in use, never above the node limit
  assign user_active = (user_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : user_count;

endmodule

### rtl/gbpc_out.sv
// ----------------------------------------------------------------------------
// gbpc_out
// Result stage: holds one result back so the final one can carry last,
// and drops anything past the result limit.
// ----------------------------------------------------------------------------
module gbpc_out (
  input  logic              clk,
  input  logic              rst,
  input  gbpc_pkg::put_t    put,
  output gbpc_pkg::result_t result,
  output logic              result_strobe
);
  import gbpc_pkg::*;

  result_t          pend;
  logic             pend_v;
  logic [CNT_W-1:0] nres;
  logic             take;

  assign take = put.valid & (nres < CNT_W'(MAX_RESULTS));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v        <= 1'b0;
      nres          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (put.fin) begin
        result_strobe <= pend_v;
        pend_v        <= 1'b0;
        nres          <= '0;
      end else if (take) begin
        result_strobe <= pend_v;
        pend_v        <= 1'b1;
        nres          <= nres + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (put.fin) begin
      result <= '{status: pend.status, node: pend.node,
                  group_index: pend.group_index, score: pend.score, last: 1'b1};
    end else if (take) begin
      result <= pend;
      pend   <= '{status: put.status, node: put.node,
                  group_index: put.group_index, score: put.score, last: 1'b0};
    end
  end

  a_fin_has_pend: assert property (@(posedge clk) disable iff (rst)
    put.fin |-> pend_v) else $error("finish with no result held");

endmodule

### rtl/gbpc_seq.sv
// ----------------------------------------------------------------------------
// gbpc_seq
// Sequencer: one list-scan unit over the neighbour memory, reused for
// edge lookup, removal, breadth-first search and suggestion tallies.
// ----------------------------------------------------------------------------
module gbpc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  gbpc_pkg::req_t                req,
  input  logic [gbpc_pkg::CNT_W-1:0]    nn,
  output logic                          busy,
  output gbpc_pkg::put_t                put,
  output logic                          ram_we,
  output logic [gbpc_pkg::LIST_AW-1:0]  ram_waddr,
  output logic [gbpc_pkg::NODE_W-1:0]   ram_wdata,
  output logic                          ram_re,
  output logic [gbpc_pkg::LIST_AW-1:0]  ram_raddr,
  input  logic [gbpc_pkg::NODE_W-1:0]   ram_rdata
);
  import gbpc_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_CHK       = 15'b000000000000010,
    S_SCAN      = 15'b000000000000100,
    S_ADD_A     = 15'b000000000001000,
    S_ADD_B     = 15'b000000000010000,
    S_ADD_W2    = 15'b000000000100000,
    S_BFS_NEXT  = 15'b000000001000000,
    S_PATH_WALK = 15'b000000010000000,
    S_PATH_OUT  = 15'b000000100000000,
    S_GRP_NEXT  = 15'b000001000000000,
    S_GRP_OUT   = 15'b000010000000000,
    S_SG_FETCH  = 15'b000100000000000,
    S_SG_FWAIT  = 15'b001000000000000,
    S_SG_OUT    = 15'b010000000000000,
    S_FIN       = 15'b100000000000000
  } state_t;

  typedef enum logic [2:0] {
    M_FIND    = 3'd0,
    M_DROP_A  = 3'd1,
    M_DROP_B  = 3'd2,
    M_BFS     = 3'd3,
    M_SG_MARK = 3'd4,
    M_SG_CAND = 3'd5
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next, launch_mode;

  logic [2:0]        op;
  logic [NODE_W-1:0] a, b;

  // scan unit
  logic [NODE_W-1:0] sc_node, sc_node_next, launch_node;
  logic [CNT_W-1:0]  sc_cnt, sc_cnt_next, sc_idx, sc_idx_next, rd_idx, rd_idx_next;
  logic              rd_v, rd_v_next, launch;

  logic              found, found_next, tgt_en, tgt_en_next;
  logic [MAX_NODES-1:0] visited, visited_next;
  logic [CNT_W-1:0]  qhead, qhead_next, qtail, qtail_next;
  logic [CNT_W-1:0]  oi, oi_next, gi, gi_next, grp, grp_next;
  logic [CNT_W-1:0]  ncand, ncand_next, best, best_next, sg_i, sg_i_next;
  logic [CNT_W-1:0]  cnt_q, cnt_q_next;
  logic [NODE_W-1:0] cur, cur_next;

  // scratch stores and neighbour counts
  logic [CNT_W-1:0]  cnt   [MAX_NODES];
  logic [NODE_W-1:0] pred  [MAX_NODES];
  logic [NODE_W-1:0] queue [MAX_NODES];
  logic [NODE_W-1:0] cand  [MAX_NODES];
  logic [CNT_W-1:0]  tally [MAX_NODES];

  logic [NODE_W-1:0] cnt_ra, q_ra, cand_ra, tally_ra;
  logic [CNT_W-1:0]  cnt_rd, tally_rd;
  logic [NODE_W-1:0] q_rd, cand_rd;

  logic              cnt_we, pred_we, q_we, cand_we, tally_we, tally_clr;
  logic [NODE_W-1:0] cnt_wa, pred_wa, q_wa, cand_wa, tally_wa;
  logic [CNT_W-1:0]  cnt_wd, tally_wd;
  logic [NODE_W-1:0] pred_wd, q_wd, cand_wd;

  logic              a_ok, b_ok, v_ok;
  logic [NODE_W-1:0] drop_tgt;

  assign busy = (state != S_IDLE);
  assign a_ok = {1'b0, a} < nn;
  assign b_ok = {1'b0, b} < nn;
  assign v_ok = {1'b0, ram_rdata} < nn;
  assign drop_tgt = (mode == M_DROP_A) ? b : a;

  // read ports of the small stores
  always_comb begin
    unique case (state)
      S_SCAN, S_ADD_B:  cnt_ra = b;
      S_BFS_NEXT:       cnt_ra = q_rd;
      S_SG_FWAIT:       cnt_ra = ram_rdata;
      default:          cnt_ra = a;
    endcase
    q_ra     = (state == S_GRP_OUT) ? oi[NODE_W-1:0] : qhead[NODE_W-1:0];
    cand_ra  = (state == S_PATH_OUT) ? NODE_W'(oi - 1'b1) : oi[NODE_W-1:0];
    tally_ra = (state == S_SG_OUT) ? cand_rd : ram_rdata;
  end

  assign cnt_rd   = cnt[cnt_ra];
  assign q_rd     = queue[q_ra];
  assign cand_rd  = cand[cand_ra];
  assign tally_rd = tally[tally_ra];

  // sequencer
  always_comb begin
    state_next   = state;
    mode_next    = mode;
    sc_node_next = sc_node;
    sc_cnt_next  = sc_cnt;
    sc_idx_next  = sc_idx;
    rd_v_next    = 1'b0;
    rd_idx_next  = sc_idx;
    found_next   = found;
    tgt_en_next  = tgt_en;
    visited_next = visited;
    qhead_next   = qhead;
    qtail_next   = qtail;
    oi_next      = oi;
    gi_next      = gi;
    grp_next     = grp;
    ncand_next   = ncand;
    best_next    = best;
    sg_i_next    = sg_i;
    cnt_q_next   = cnt_q;
    cur_next     = cur;
    launch       = 1'b0;
    launch_node  = a;
    launch_mode  = mode;
    cnt_we = 1'b0; cnt_wa = a;        cnt_wd = '0;
    pred_we = 1'b0; pred_wa = ram_rdata; pred_wd = sc_node;
    q_we = 1'b0;   q_wa = qtail[NODE_W-1:0]; q_wd = ram_rdata;
    cand_we = 1'b0; cand_wa = ncand[NODE_W-1:0]; cand_wd = ram_rdata;
    tally_we = 1'b0; tally_wa = ram_rdata; tally_wd = tally_rd + 1'b1;
    tally_clr = 1'b0;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0;
    ram_re = 1'b0; ram_raddr = {sc_node, sc_idx[NODE_W-1:0]};
    put = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHK;
        end
      end

      // decode the request
      S_CHK: begin
        state_next = S_FIN;
        case (op)
          OP_ADD, OP_REMOVE, OP_PATH: begin
            found_next = 1'b0;
            if (!(a_ok && b_ok)) begin
              put.valid = 1'b1; put.status = ST_ERR;
            end else if (op == OP_ADD) begin
              if (a == b) begin
                put.valid = 1'b1; put.status = ST_MISS;
              end else begin
                launch = 1'b1; launch_node = a; launch_mode = M_FIND;
              end
            end else if (op == OP_REMOVE) begin
              launch = 1'b1; launch_node = a; launch_mode = M_DROP_A;
            end else if (a == b) begin
              put.valid = 1'b1; put.status = ST_MISS;
            end else begin
              visited_next    = '0;
              visited_next[a] = 1'b1;
              q_we = 1'b1; q_wa = '0; q_wd = a;
              qtail_next  = CNT_W'(1);
              qhead_next  = '0;
              tgt_en_next = 1'b1;
              state_next  = S_BFS_NEXT;
            end
          end
          OP_GROUPS: begin
            if (nn == '0) begin
              put.valid = 1'b1; put.status = ST_MISS;
            end else begin
              visited_next = '0;
              gi_next      = '0;
              grp_next     = '0;
              tgt_en_next  = 1'b0;
              state_next   = S_GRP_NEXT;
            end
          end
          OP_SUGGEST: begin
            if (!a_ok) begin
              put.valid = 1'b1; put.status = ST_ERR;
            end else begin
              visited_next    = '0;
              visited_next[a] = 1'b1;
              tally_clr  = 1'b1;
              ncand_next = '0;
              best_next  = '0;
              launch = 1'b1; launch_node = a; launch_mode = M_SG_MARK;
            end
          end
          default: begin
            put.valid = 1'b1; put.status = ST_ERR;
          end
        endcase
      end

      // list scan: issue one read a cycle, handle its data in the cycle after
      S_SCAN: begin
        if (sc_idx < sc_cnt) begin
          ram_re      = 1'b1;
          rd_v_next   = 1'b1;
          sc_idx_next = sc_idx + 1'b1;
        end
        if (rd_v) begin
          unique case (mode)
            M_FIND: begin
              if (ram_rdata == b) found_next = 1'b1;
            end
            M_DROP_A, M_DROP_B: begin
              if (found) begin
                ram_we    = 1'b1;
                ram_waddr = {sc_node, NODE_W'(rd_idx - 1'b1)};
                ram_wdata = ram_rdata;
              end else if (ram_rdata == drop_tgt) begin
                found_next = 1'b1;
              end
            end
            M_BFS: begin
              if (v_ok && !visited[ram_rdata]) begin
                visited_next[ram_rdata] = 1'b1;
                pred_we = 1'b1;
                if (!qtail[CNT_W-1]) begin
                  q_we       = 1'b1;
                  qtail_next = qtail + 1'b1;
                end
                if (tgt_en && ram_rdata == b) found_next = 1'b1;
              end
            end
            M_SG_MARK: begin
              visited_next[ram_rdata] = 1'b1;
            end
            M_SG_CAND: begin
              if (v_ok && !visited[ram_rdata]) begin
                if (tally_rd == '0 && !ncand[CNT_W-1]) begin
                  cand_we    = 1'b1;
                  ncand_next = ncand + 1'b1;
                end
                tally_we = 1'b1;
                if (tally_wd > best) best_next = tally_wd;
              end
            end
            default: ;
          endcase
        end
        // scan finished
        if (sc_idx >= sc_cnt && !rd_v) begin
          unique case (mode)
            M_FIND: begin
              if (found) begin
                put.valid = 1'b1; put.status = ST_MISS;
                state_next = S_FIN;
              end else begin
                state_next = S_ADD_A;
              end
            end
            M_DROP_A: begin
              if (!found) begin
                put.valid = 1'b1; put.status = ST_MISS;
                state_next = S_FIN;
              end else begin
                cnt_we = 1'b1; cnt_wa = a; cnt_wd = sc_cnt - 1'b1;
                found_next = 1'b0;
                launch = 1'b1; launch_node = b; launch_mode = M_DROP_B;
              end
            end
            M_DROP_B: begin
              if (found) begin
                cnt_we = 1'b1; cnt_wa = b; cnt_wd = sc_cnt - 1'b1;
              end
              put.valid  = 1'b1; put.status = ST_OK;
              state_next = S_FIN;
            end
            M_BFS: begin
              qhead_next = qhead + 1'b1;
              state_next = S_BFS_NEXT;
            end
            M_SG_MARK: begin
              sg_i_next  = '0;
              state_next = S_SG_FETCH;
            end
            M_SG_CAND: begin
              state_next = S_SG_FETCH;
            end
            default: state_next = S_FIN;
          endcase
        end
      end

      // edge insert, one list at a time
      S_ADD_A: begin
        if (cnt_rd >= CNT_W'(MAX_DEGREE)) begin
          put.valid = 1'b1; put.status = ST_ERR;
          state_next = S_FIN;
        end else begin
          cnt_q_next = cnt_rd;
          state_next = S_ADD_B;
        end
      end
      S_ADD_B: begin
        if (cnt_rd >= CNT_W'(MAX_DEGREE)) begin
          put.valid = 1'b1; put.status = ST_ERR;
          state_next = S_FIN;
        end else begin
          ram_we = 1'b1; ram_waddr = {a, cnt_q[NODE_W-1:0]}; ram_wdata = b;
          cnt_we = 1'b1; cnt_wa = a; cnt_wd = cnt_q + 1'b1;
          cnt_q_next = cnt_rd;
          state_next = S_ADD_W2;
        end
      end
      S_ADD_W2: begin
        ram_we = 1'b1; ram_waddr = {b, cnt_q[NODE_W-1:0]}; ram_wdata = a;
        cnt_we = 1'b1; cnt_wa = b; cnt_wd = cnt_q + 1'b1;
        put.valid  = 1'b1; put.status = ST_OK;
        state_next = S_FIN;
      end

      // breadth-first search: next queue entry
      S_BFS_NEXT: begin
        if (qhead < qtail && !found) begin
          launch = 1'b1; launch_node = q_rd; launch_mode = M_BFS;
        end else if (op == OP_PATH) begin
          if (found) begin
            cur_next   = b;
            oi_next    = '0;
            state_next = S_PATH_WALK;
          end else begin
            put.valid = 1'b1; put.status = ST_MISS;
            state_next = S_FIN;
          end
        end else begin
          oi_next    = '0;
          state_next = S_GRP_OUT;
        end
      end

      // follow predecessors from target back to source
      S_PATH_WALK: begin
        cand_we = 1'b1; cand_wa = oi[NODE_W-1:0]; cand_wd = cur;
        oi_next = oi + 1'b1;
        if (cur == a) begin
          state_next = S_PATH_OUT;
        end else begin
          cur_next = pred[cur];
        end
      end
      S_PATH_OUT: begin
        put.valid = 1'b1; put.status = ST_OK; put.node = cand_rd;
        oi_next   = oi - 1'b1;
        if (oi == CNT_W'(1)) state_next = S_FIN;
      end

      // components: find the next unvisited node
      S_GRP_NEXT: begin
        if (gi >= nn) begin
          state_next = S_FIN;
        end else if (visited[gi[NODE_W-1:0]]) begin
          gi_next = gi + 1'b1;
        end else begin
          visited_next[gi[NODE_W-1:0]] = 1'b1;
          q_we = 1'b1; q_wa = '0; q_wd = gi[NODE_W-1:0];
          qtail_next = CNT_W'(1);
          qhead_next = '0;
          found_next = 1'b0;
          state_next = S_BFS_NEXT;
        end
      end
      S_GRP_OUT: begin
        put.valid = 1'b1; put.status = ST_OK;
        put.node = q_rd; put.group_index = grp[NODE_W-1:0];
        oi_next = oi + 1'b1;
        if (oi + 1'b1 == qtail) begin
          grp_next   = grp + 1'b1;
          gi_next    = gi + 1'b1;
          state_next = S_GRP_NEXT;
        end
      end

      // suggestion: walk the asking node's friends
      S_SG_FETCH: begin
        if (sg_i < cnt_rd) begin
          ram_re     = 1'b1;
          ram_raddr  = {a, sg_i[NODE_W-1:0]};
          state_next = S_SG_FWAIT;
        end else if (ncand == '0) begin
          put.valid = 1'b1; put.status = ST_MISS;
          state_next = S_FIN;
        end else begin
          oi_next    = '0;
          state_next = S_SG_OUT;
        end
      end
      S_SG_FWAIT: begin
        sg_i_next = sg_i + 1'b1;
        if (v_ok) begin
          launch = 1'b1; launch_node = ram_rdata; launch_mode = M_SG_CAND;
        end else begin
          state_next = S_SG_FETCH;
        end
      end
      S_SG_OUT: begin
        if (tally_rd == best) begin
          put.valid = 1'b1; put.status = ST_OK;
          put.node  = cand_rd; put.score = sat_score(best);
        end
        oi_next = oi + 1'b1;
        if (oi + 1'b1 == ncand) state_next = S_FIN;
      end

      S_FIN: begin
        put.fin    = 1'b1;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    // start a list scan
    if (launch) begin
      sc_node_next = launch_node;
      sc_cnt_next  = cnt_rd;
      sc_idx_next  = '0;
      mode_next    = launch_mode;
      state_next   = S_SCAN;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mode    <= M_FIND;
      rd_v    <= 1'b0;
      found   <= 1'b0;
      tgt_en  <= 1'b0;
      visited <= '0;
      qhead   <= '0;
      qtail   <= '0;
      sc_idx  <= '0;
      sc_cnt  <= '0;
    end else begin
      state   <= state_next;
      mode    <= mode_next;
      rd_v    <= rd_v_next;
      found   <= found_next;
      tgt_en  <= tgt_en_next;
      visited <= visited_next;
      qhead   <= qhead_next;
      qtail   <= qtail_next;
      sc_idx  <= sc_idx_next;
      sc_cnt  <= sc_cnt_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= req.op;
      a  <= req.node_a;
      b  <= req.node_b;
    end
    sc_node <= sc_node_next;
    rd_idx  <= rd_idx_next;
    oi      <= oi_next;
    gi      <= gi_next;
    grp     <= grp_next;
    ncand   <= ncand_next;
    best    <= best_next;
    sg_i    <= sg_i_next;
    cnt_q   <= cnt_q_next;
    cur     <= cur_next;
  end

  // neighbour counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) cnt[i] <= '0;
    end else if (cnt_we) begin
      cnt[cnt_wa] <= cnt_wd;
    end
  end

  // search scratch
  always_ff @(posedge clk) begin
    if (pred_we) pred[pred_wa] <= pred_wd;
    if (q_we)    queue[q_wa]   <= q_wd;
    if (cand_we) cand[cand_wa] <= cand_wd;
    if (tally_clr) begin
      for (int i = 0; i < MAX_NODES; i++) tally[i] <= '0;
    end else if (tally_we) begin
      tally[tally_wa] <= tally_wd;
    end
  end

  a_qtail_bound: assert property (@(posedge clk) disable iff (rst)
    qtail <= CNT_W'(MAX_NODES)) else $error("queue tail past node limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> sc_idx <= sc_cnt) else $error("scan index past count");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> state == S_IDLE) else $error("finish not followed by idle");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the graph search engine. A short table of requests
// covers error codes, edge cases and every operation, then random phases
// grow and query graphs under several user counts. Each result is checked
// against an in-bench model of the neighbour lists and searches.
// ----------------------------------------------------------------------------
module tb;
  import gbpc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int RAND_ITEMS  = 155;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  req_t              req;
  result_t           result;
  logic              result_strobe;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  graph_bfs_path_component_engine_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result(result), .result_strobe(result_strobe), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // graph mirror
  logic [NODE_W-1:0] adj [MAX_NODES][MAX_DEGREE];
  int                degree [MAX_NODES];
  int                users;
  bit                seen [MAX_NODES];
  int                came_from [MAX_NODES];
  int                order_q [MAX_NODES];
  int                order_len;
  result_t           item_results[$];
  result_t           pending_results[$];

  int errors;
  int cycles;
  int requests_sent;
  int results_seen;

  function automatic int active_users();
    return users > MAX_NODES ? MAX_NODES : users;
  endfunction

  function automatic void emit(int st, int nd, int grp, int sc);
    result_t r;
    if (item_results.size() >= MAX_RESULTS) return;
    r.status      = st[1:0];
    r.node        = nd[NODE_W-1:0];
    r.group_index = grp[NODE_W-1:0];
    r.score       = sc > 31 ? 5'd31 : sc[NODE_W-1:0];
    r.last        = 1'b0;
    item_results.insert(item_results.size(), r);
  endfunction

  function automatic int find_pos(int u, int v);
    for (int i = 0; i < degree[u]; i++)
      if (adj[u][i] == v) return i;
    return -1;
  endfunction

  function automatic void unlink(int u, int v);
    int p;
    p = find_pos(u, v);
    if (p < 0) return;
    for (int i = p; i + 1 < degree[u]; i++) adj[u][i] = adj[u][i+1];
    degree[u]--;
  endfunction

  // breadth-first walk; order_q holds discovery order
  function automatic bit walk(int src, int target);
    int head, n, u, v;
    bit found;
    head = 0;
    n = active_users();
    found = 0;
    came_from[src] = -1;
    seen[src] = 1;
    order_q[0] = src;
    order_len = 1;
    while (head < order_len && !found) begin
      u = order_q[head];
      for (int i = 0; i < degree[u]; i++) begin
        v = adj[u][i];
        if (v >= n || seen[v]) continue;
        seen[v] = 1;
        came_from[v] = u;
        if (order_len < MAX_NODES) begin
          order_q[order_len] = v;
          order_len++;
        end
        if (v == target) found = 1;
      end
      head++;
    end
    return found;
  endfunction

  function automatic void predict_path(int a, int b);
    int trail[$];
    int cur, n;
    n = active_users();
    foreach (seen[i]) seen[i] = 0;
    if (a == b || !walk(a, b)) begin
      emit(ST_MISS, 0, 0, 0);
      return;
    end
    cur = b;
    while (cur >= 0 && cur < MAX_NODES && trail.size() < n) begin
      trail.push_front(cur);
      cur = came_from[cur];
    end
    foreach (trail[i]) emit(ST_OK, trail[i], 0, 0);
  endfunction

  function automatic void predict_groups();
    int n, g;
    n = active_users();
    g = 0;
    if (n == 0) begin
      emit(ST_MISS, 0, 0, 0);
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    for (int i = 0; i < n; i++) begin
      if (seen[i]) continue;
      void'(walk(i, -1));
      for (int j = 0; j < order_len; j++) emit(ST_OK, order_q[j], g, 0);
      g++;
    end
  endfunction

  function automatic void predict_suggest(int a);
    int tally [MAX_NODES];
    int cands[$];
    int n, best, f, c;
    n = active_users();
    best = 0;
    foreach (seen[i]) begin
      seen[i] = 0;
      tally[i] = 0;
    end
    seen[a] = 1;
    for (int i = 0; i < degree[a]; i++) seen[adj[a][i]] = 1;
    for (int i = 0; i < degree[a]; i++) begin
      f = adj[a][i];
      if (f >= n) continue;
      for (int j = 0; j < degree[f]; j++) begin
        c = adj[f][j];
        if (c >= n || seen[c]) continue;
        if (tally[c] == 0) cands.insert(cands.size(), c);
        tally[c]++;
        if (tally[c] > best) best = tally[c];
      end
    end
    if (cands.size() == 0) begin
      emit(ST_MISS, 0, 0, 0);
      return;
    end
    foreach (cands[i])
      if (tally[cands[i]] == best) emit(ST_OK, cands[i], 0, best);
  endfunction

  // work out the results of one request and update the mirror
  function automatic void predict_request(req_t r);
    int a, b, n;
    a = r.node_a;
    b = r.node_b;
    n = active_users();
    item_results.delete();
    case (r.op)
      OP_ADD, OP_REMOVE, OP_PATH: begin
        if (a >= n || b >= n) emit(ST_ERR, 0, 0, 0);
        else if (r.op == OP_ADD) begin
          if (a == b || find_pos(a, b) >= 0) emit(ST_MISS, 0, 0, 0);
          else if (degree[a] >= MAX_DEGREE || degree[b] >= MAX_DEGREE)
            emit(ST_ERR, 0, 0, 0);
          else begin
            adj[a][degree[a]] = b[NODE_W-1:0];
            degree[a]++;
            adj[b][degree[b]] = a[NODE_W-1:0];
            degree[b]++;
            emit(ST_OK, 0, 0, 0);
          end
        end else if (r.op == OP_REMOVE) begin
          if (find_pos(a, b) < 0) emit(ST_MISS, 0, 0, 0);
          else begin
            unlink(a, b);
            unlink(b, a);
            emit(ST_OK, 0, 0, 0);
          end
        end else predict_path(a, b);
      end
      OP_GROUPS: predict_groups();
      OP_SUGGEST: begin
        if (a >= n) emit(ST_ERR, 0, 0, 0);
        else predict_suggest(a);
      end
      default: emit(ST_ERR, 0, 0, 0);
    endcase
    if (item_results.size() == 0) emit(ST_MISS, 0, 0, 0);
    item_results[item_results.size()-1].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d node=%0d grp=%0d sc=%0d last=%0d",
                 $time, result.status, result.node, result.group_index,
                 result.score, result.last);
        errors++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (result.status !== want.status || result.node !== want.node ||
            result.group_index !== want.group_index ||
            result.score !== want.score || result.last !== want.last) begin
          $display("%0t: mismatch expected st=%0d node=%0d grp=%0d sc=%0d last=%0d",
                   $time, want.status, want.node, want.group_index, want.score,
                   want.last);
          $display("%0t:          actual   st=%0d node=%0d grp=%0d sc=%0d last=%0d",
                   $time, result.status, result.node, result.group_index,
                   result.score, result.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // issue one request; returns at the edge that takes it
  task automatic issue(req_t r, bit typed, result_t want);
    start <= 1'b1;
    req   <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
    predict_request(r);
    if (typed) pending_results.insert(pending_results.size(), want);
    else foreach (item_results[i])
      pending_results.insert(pending_results.size(), item_results[i]);
    requests_sent++;
  endtask

  // hold off until every result is in and the engine is idle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    do @(negedge clk); while (busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_user_count(int value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_USER_COUNT, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    users = value & 63;
    @(posedge clk);
  endtask

  // directed table
  typedef struct {
    int      cfg;
    req_t    r;
    bit      typed;
    result_t want;
  } row_t;
  row_t rows[$];

  function automatic void row(int cfg, logic [2:0] op, int a, int b, bit typed,
                              logic [1:0] st);
    row_t w;
    w.cfg   = cfg;
    w.r     = '{op: op, node_a: a[NODE_W-1:0], node_b: b[NODE_W-1:0]};
    w.typed = typed;
    w.want  = '{status: st, node: '0, group_index: '0, score: '0, last: 1'b1};
    rows.insert(rows.size(), w);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int n, pick;
    n = active_users();
    pick = $urandom_range(99);
    if (pick < 40)      r.op = OP_ADD;
    else if (pick < 55) r.op = OP_REMOVE;
    else if (pick < 75) r.op = OP_PATH;
    else if (pick < 85) r.op = OP_GROUPS;
    else if (pick < 95) r.op = OP_SUGGEST;
    else                r.op = 3'($urandom_range(7, 5));
    if (n > 0 && $urandom_range(99) < 85) begin
      r.node_a = NODE_W'($urandom_range(n - 1));
      r.node_b = NODE_W'($urandom_range(n - 1));
    end else begin
      r.node_a = NODE_W'($urandom);
      r.node_b = NODE_W'($urandom);
    end
    return r;
  endfunction

  // stimulus
  initial begin
    int phase_counts [6];
    result_t none;
    req_t    r;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    requests_sent = 0;
    results_seen = 0;
    users = 0;
    none = '0;
    foreach (degree[i]) degree[i] = 0;
    phase_counts = '{32, 12, 63, 5, 20, 33};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no users yet, then a small graph
    row(-1, OP_GROUPS,  0,  0, 1, ST_MISS);
    row(-1, OP_ADD,     0,  1, 1, ST_ERR);
    row(-1, 3'd7,       0,  0, 1, ST_ERR);
    row( 8, OP_ADD,     0,  1, 1, ST_OK);
    row(-1, OP_ADD,     1,  0, 1, ST_MISS);
    row(-1, OP_ADD,     2,  2, 1, ST_MISS);
    row(-1, OP_ADD,     0,  8, 1, ST_ERR);
    row(-1, OP_ADD,     1,  2, 1, ST_OK);
    row(-1, OP_ADD,     2,  3, 1, ST_OK);
    row(-1, OP_ADD,     0,  3, 1, ST_OK);
    row(-1, OP_PATH,    0,  3, 0, ST_OK);
    row(-1, OP_PATH,    0,  0, 1, ST_MISS);
    row(-1, OP_PATH,    0,  5, 1, ST_MISS);
    row(-1, OP_PATH,   31,  0, 1, ST_ERR);
    row(-1, OP_PATH,    0, 31, 1, ST_ERR);
    row(-1, OP_SUGGEST, 1,  0, 0, ST_OK);
    row(-1, OP_SUGGEST, 5,  0, 1, ST_MISS);
    row(-1, OP_SUGGEST,31,  0, 1, ST_ERR);
    row(-1, OP_GROUPS,  0,  0, 0, ST_OK);
    row(-1, OP_REMOVE,  0,  1, 1, ST_OK);
    row(-1, OP_REMOVE,  0,  1, 1, ST_MISS);
    row(-1, OP_REMOVE,  9,  0, 1, ST_ERR);
    row(-1, 3'd5,       0,  0, 1, ST_ERR);
    row(-1, OP_ADD,     7,  6, 1, ST_OK);
    row(-1, OP_PATH,    7,  6, 0, ST_OK);
    row( 3, OP_GROUPS,  0,  0, 0, ST_OK);
    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) write_user_count(rows[i].cfg);
      issue(rows[i].r, rows[i].typed, rows[i].want);
    end

    // random phases over several user counts; count 5 remains stale-heavy
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 30 == 0) write_user_count(phase_counts[k / 30]);
      if (k == 100) drain();
      r = random_request();
      issue(r, 0, none);
      if ((k < 50 || k > 90) && $urandom_range(99) < 20) begin
        start <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
    start <= 1'b0;

    // wind down
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("tb: %0d requests over user counts 0..63 and all five operations,",
             requests_sent);
    $display("tb: %0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
